// ===== sv/scs_pkg.sv =====
// Shared types, constants and the arctangent table for the shoulder servo core.
// No dependencies; used by scs_cordic and spherical_to_shoulder_servo_core.
package scs_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;
    localparam int QF              = 30;
    localparam int W               = 36;
    localparam int MW              = 32;
    localparam int COUNT_SHIFT     = 50;

    typedef logic signed [W-1:0]  word_t;
    typedef logic signed [MW-1:0] mword_t;

    typedef struct packed {
        logic  f0;
        logic  f1;
        word_t aux;
    } side_t;

    localparam word_t K_Q30       = 36'sd652032874;
    localparam word_t PI_Q30      = 36'sd3373259426;
    localparam word_t HALF_PI_Q30 = 36'sd1686629713;
    localparam word_t TWO_PI_Q30  = 36'sd6746518852;
    localparam logic [29:0] COUNT_SCALE = 30'd683565276;

    localparam logic [2:0] ADDR_ROLL_OFFSET = 3'd0;
    localparam logic [2:0] ADDR_ELBOW_POSE  = 3'd4;
    localparam logic       REG_ROLL_OFFSET  = 1'b0;
    localparam logic       REG_ELBOW_POSE   = 1'b1;

    function automatic word_t atan_q30(input int i);
        word_t r;
        case (i)
            0:  r = 36'sh03243F6A8;
            1:  r = 36'sh01DAC6705;
            2:  r = 36'sh00FADBAFC;
            3:  r = 36'sh007F56EA6;
            4:  r = 36'sh003FEAB76;
            5:  r = 36'sh001FFD55B;
            6:  r = 36'sh000FFFAAA;
            7:  r = 36'sh0007FFF55;
            8:  r = 36'sh0003FFFEA;
            9:  r = 36'sh0001FFFFD;
            10: r = 36'sh0000FFFFF;
            11: r = 36'sh00007FFFF;
            12: r = 36'sh00003FFFF;
            13: r = 36'sh00001FFFF;
            14: r = 36'sh00000FFFF;
            15: r = 36'sh000007FFF;
            16: r = 36'sh000003FFF;
            17: r = 36'sh000001FFF;
            18: r = 36'sh000000FFF;
            19: r = 36'sh0000007FF;
            20: r = 36'sh0000003FF;
            21: r = 36'sh0000001FF;
            22: r = 36'sh0000000FF;
            23: r = 36'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/scs_cordic.sv =====
// Pipelined CORDIC chain, one register stage per iteration, rotation or vectoring.
// Depends on scs_pkg for word and sideband types and the arctangent table.
module scs_cordic (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vectoring,
    input  logic           in_valid,
    input  scs_pkg::word_t in_x,
    input  scs_pkg::word_t in_y,
    input  scs_pkg::word_t in_z,
    input  scs_pkg::side_t in_side,
    output logic           out_valid,
    output scs_pkg::word_t out_x,
    output scs_pkg::word_t out_y,
    output scs_pkg::word_t out_z,
    output scs_pkg::side_t out_side
);

    localparam int N = scs_pkg::CORDIC_STAGES;

    logic           valid_reg [N];
    scs_pkg::word_t x_reg     [N];
    scs_pkg::word_t y_reg     [N];
    scs_pkg::word_t z_reg     [N];
    scs_pkg::side_t side_reg  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic           v_src;
        scs_pkg::word_t x_src, y_src, z_src;
        scs_pkg::side_t s_src;
        scs_pkg::word_t x_next, y_next, z_next;
        logic           pos;

        if (i == 0) begin : g_first
            assign v_src = in_valid;
            assign x_src = in_x;
            assign y_src = in_y;
            assign z_src = in_z;
            assign s_src = in_side;
        end else begin : g_rest
            assign v_src = valid_reg[i-1];
            assign x_src = x_reg[i-1];
            assign y_src = y_reg[i-1];
            assign z_src = z_reg[i-1];
            assign s_src = side_reg[i-1];
        end

        // rotation follows the residual angle, vectoring drives y toward zero
        assign pos = vectoring ? y_src[scs_pkg::W-1] : ~z_src[scs_pkg::W-1];

        always_comb
        begin
            if (pos)
            begin
                x_next = x_src - (y_src >>> i);
                y_next = y_src + (x_src >>> i);
                z_next = z_src - scs_pkg::atan_q30(i);
            end
            else
            begin
                x_next = x_src + (y_src >>> i);
                y_next = y_src - (x_src >>> i);
                z_next = z_src + scs_pkg::atan_q30(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= s_src;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== sv/spherical_to_shoulder_servo_core.sv =====
// Shoulder servo goals from a polar/azimuth pointing direction.
// Throughput: one item per cycle unless the output stalls;
// three CORDIC chains in series, one stage per iteration.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits; roll_offset resets to 1484, elbow_pose to 3072.
// Depends on scs_pkg and scs_cordic.
module spherical_to_shoulder_servo_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // polar_q13[15:0], azimuth_q13[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // roll_position[11:0], pitch_position[23:12],
                                   // elbow_position[35:24], zero[39:36]
    output logic [0:0]  m_tuser,   // accepted[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SH = scs_pkg::QF - scs_pkg::ANGLE_FRAC_BITS;

    logic        en;
    logic [11:0] roll_offset_reg;
    logic [11:0] elbow_pose_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_offset_reg <= 12'd1484;
            elbow_pose_reg  <= 12'd3072;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                scs_pkg::REG_ROLL_OFFSET: roll_offset_reg <= pwdata[11:0];
                scs_pkg::REG_ELBOW_POSE:  elbow_pose_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            scs_pkg::REG_ROLL_OFFSET: prdata = {20'd0, roll_offset_reg};
            scs_pkg::REG_ELBOW_POSE:  prdata = {20'd0, elbow_pose_reg};
            default:                  prdata = '0;
        endcase
    end

    // stage 0: widen to Q30 and wrap into [-pi, pi]
    function automatic scs_pkg::word_t wrap_turn(input logic [15:0] raw);
        scs_pkg::word_t v;
        v = scs_pkg::word_t'(signed'(raw)) <<< SH;
        if (v > scs_pkg::PI_Q30)
            v = v - scs_pkg::TWO_PI_Q30;
        else if (v < -scs_pkg::PI_Q30)
            v = v + scs_pkg::TWO_PI_Q30;
        return v;
    endfunction

    logic           v0_reg;
    scs_pkg::word_t p0_reg, a0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= wrap_turn(s_tdata[15:0]);
            a0_reg <= wrap_turn(s_tdata[31:16]);
        end
    end

    // stage 1: fold into [-pi/2, pi/2], remember the sign flip
    logic           v1_reg;
    scs_pkg::word_t p1_reg, a1_reg;
    logic           np1_reg, na1_reg;
    scs_pkg::word_t p1_next, a1_next;
    logic           np1_next, na1_next;

    always_comb
    begin
        p1_next  = p0_reg;
        np1_next = 1'b0;
        if (p0_reg > scs_pkg::HALF_PI_Q30)
        begin
            p1_next  = p0_reg - scs_pkg::PI_Q30;
            np1_next = 1'b1;
        end
        else if (p0_reg < -scs_pkg::HALF_PI_Q30)
        begin
            p1_next  = p0_reg + scs_pkg::PI_Q30;
            np1_next = 1'b1;
        end
        a1_next  = a0_reg;
        na1_next = 1'b0;
        if (a0_reg > scs_pkg::HALF_PI_Q30)
        begin
            a1_next  = a0_reg - scs_pkg::PI_Q30;
            na1_next = 1'b1;
        end
        else if (a0_reg < -scs_pkg::HALF_PI_Q30)
        begin
            a1_next  = a0_reg + scs_pkg::PI_Q30;
            na1_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            a1_reg  <= a1_next;
            np1_reg <= np1_next;
            na1_reg <= na1_next;
        end
    end

    // sin/cos chains
    logic           rp_valid, ra_valid;
    scs_pkg::word_t rp_x, rp_y, rp_z, ra_x, ra_y, ra_z;
    scs_pkg::side_t rp_side, ra_side, rp_in_side, ra_in_side;

    assign rp_in_side = '{f0: np1_reg, f1: 1'b0, aux: '0};
    assign ra_in_side = '{f0: na1_reg, f1: 1'b0, aux: '0};

    scs_cordic u_rot_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b0),
        .in_valid  (v1_reg),
        .in_x      (scs_pkg::K_Q30),
        .in_y      ('0),
        .in_z      (p1_reg),
        .in_side   (rp_in_side),
        .out_valid (rp_valid),
        .out_x     (rp_x),
        .out_y     (rp_y),
        .out_z     (rp_z),
        .out_side  (rp_side)
    );

    scs_cordic u_rot_azimuth (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b0),
        .in_valid  (v1_reg),
        .in_x      (scs_pkg::K_Q30),
        .in_y      ('0),
        .in_z      (a1_reg),
        .in_side   (ra_in_side),
        .out_valid (ra_valid),
        .out_x     (ra_x),
        .out_y     (ra_y),
        .out_z     (ra_z),
        .out_side  (ra_side)
    );

    // stage: apply the fold sign flip
    logic           v2_reg;
    scs_pkg::mword_t sp_reg, cp_reg, sa_reg, ca_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= rp_valid & ra_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= scs_pkg::mword_t'(rp_side.f0 ? -rp_y : rp_y);
            cp_reg <= scs_pkg::mword_t'(rp_side.f0 ? -rp_x : rp_x);
            sa_reg <= scs_pkg::mword_t'(ra_side.f0 ? -ra_y : ra_y);
            ca_reg <= scs_pkg::mword_t'(ra_side.f0 ? -ra_x : ra_x);
        end
    end

    // stage: x and y products
    logic            v3_reg;
    scs_pkg::word_t  x3_reg, y3_reg, z3_reg;
    logic signed [2*scs_pkg::MW-1:0] px_prod, py_prod;

    assign px_prod = sp_reg * ca_reg;
    assign py_prod = sp_reg * sa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_reg <= scs_pkg::word_t'(px_prod >>> scs_pkg::QF);
            y3_reg <= scs_pkg::word_t'(py_prod >>> scs_pkg::QF);
            z3_reg <= scs_pkg::word_t'(cp_reg);
        end
    end

    // stage: reject test, half-plane swap for atan2(y, z)
    logic           v4_reg;
    scs_pkg::word_t vx4_reg, vy4_reg, st4_reg;
    scs_pkg::side_t s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg <= '{f0: (x3_reg > 0), f1: (y3_reg == 0 && z3_reg == 0), aux: x3_reg};
            if (z3_reg < 0)
            begin
                vx4_reg <= -z3_reg;
                vy4_reg <= -y3_reg;
                st4_reg <= (y3_reg >= 0) ? scs_pkg::PI_Q30 : -scs_pkg::PI_Q30;
            end
            else
            begin
                vx4_reg <= z3_reg;
                vy4_reg <= y3_reg;
                st4_reg <= '0;
            end
        end
    end

    logic           vp_valid;
    scs_pkg::word_t vp_x, vp_y, vp_z;
    scs_pkg::side_t vp_side;

    scs_cordic u_vec_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b1),
        .in_valid  (v4_reg),
        .in_x      (vx4_reg),
        .in_y      (vy4_reg),
        .in_z      (st4_reg),
        .in_side   (s4_reg),
        .out_valid (vp_valid),
        .out_x     (vp_x),
        .out_y     (vp_y),
        .out_z     (vp_z),
        .out_side  (vp_side)
    );

    // stage: magnitude scaling
    logic            v5_reg;
    scs_pkg::word_t  mag5_reg, x5_reg;
    scs_pkg::side_t  s5_reg;
    logic signed [2*scs_pkg::MW-1:0] mag_prod;

    assign mag_prod = scs_pkg::mword_t'(vp_x) * scs_pkg::mword_t'(scs_pkg::K_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= vp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag5_reg <= vp_side.f1 ? '0 : scs_pkg::word_t'(mag_prod >>> scs_pkg::QF);
            x5_reg   <= vp_side.aux;
            s5_reg   <= '{f0: vp_side.f0, f1: vp_side.f1, aux: vp_z};
        end
    end

    logic           vr_valid;
    scs_pkg::word_t vr_x, vr_y, vr_z;
    scs_pkg::side_t vr_side;

    scs_cordic u_vec_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b1),
        .in_valid  (v5_reg),
        .in_x      (x5_reg),
        .in_y      (mag5_reg),
        .in_z      ('0),
        .in_side   (s5_reg),
        .out_valid (vr_valid),
        .out_x     (vr_x),
        .out_y     (vr_y),
        .out_z     (vr_z),
        .out_side  (vr_side)
    );

    // stage: angle magnitude to counts
    logic        v6_reg;
    logic [11:0] mr6_reg, mp6_reg;
    logic        nr6_reg, np6_reg, acc6_reg, zero6_reg;
    logic [31:0] roll_abs, pitch_abs;
    logic [61:0] roll_prod, pitch_prod;

    assign roll_abs   = 32'(vr_z[scs_pkg::W-1] ? -vr_z : vr_z);
    assign pitch_abs  = 32'(vr_side.aux[scs_pkg::W-1] ? -vr_side.aux : vr_side.aux);
    assign roll_prod  = roll_abs * scs_pkg::COUNT_SCALE;
    assign pitch_prod = pitch_abs * scs_pkg::COUNT_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= vr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr6_reg   <= roll_prod[scs_pkg::COUNT_SHIFT +: 12];
            mp6_reg   <= pitch_prod[scs_pkg::COUNT_SHIFT +: 12];
            nr6_reg   <= vr_z[scs_pkg::W-1];
            np6_reg   <= vr_side.aux[scs_pkg::W-1];
            acc6_reg  <= vr_side.f0;
            zero6_reg <= vr_side.f1;
        end
    end

    // output stage: wrap signs, add roll offset, zero a rejected item
    logic        out_valid_reg;
    logic [11:0] roll_out_reg, pitch_out_reg, elbow_out_reg;
    logic        acc_out_reg;
    logic [11:0] roll_cnt, pitch_cnt;

    assign roll_cnt  = nr6_reg ? 12'(-mr6_reg) : mr6_reg;
    assign pitch_cnt = zero6_reg ? 12'd0 : (np6_reg ? 12'(-mp6_reg) : mp6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_out_reg   <= acc6_reg;
            roll_out_reg  <= acc6_reg ? roll_offset_reg + roll_cnt : 12'd0;
            pitch_out_reg <= acc6_reg ? pitch_cnt : 12'd0;
            elbow_out_reg <= acc6_reg ? elbow_pose_reg : 12'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, elbow_out_reg, pitch_out_reg, roll_out_reg};
    assign m_tuser  = acc_out_reg;

endmodule
